### rtl/sfs_pkg.sv
// Shared types and constants for the seek/flee steering block.
package sfs_pkg;

    localparam int unsigned FracBitsDefault = 16;
    localparam int unsigned CoordW   = 32;
    localparam int unsigned DiffW    = 33;
    localparam int unsigned AccelW   = 31;
    localparam int unsigned SumW     = 2 * DiffW;
    localparam int unsigned ProdW    = DiffW + AccelW;
    localparam int unsigned RootW    = DiffW;
    localparam int unsigned SqRemW   = RootW + 2;
    localparam int unsigned QuotW    = AccelW;
    localparam int unsigned DivRemW  = RootW;

    localparam logic CmdSeek = 1'b0;
    localparam logic CmdFlee = 1'b1;

    typedef struct packed {
        logic                     cmd;
        logic signed [CoordW-1:0] target_x;
        logic signed [CoordW-1:0] target_y;
        logic signed [CoordW-1:0] pos_x;
        logic signed [CoordW-1:0] pos_y;
    } t_in_word;

    typedef struct packed {
        logic signed [CoordW-1:0] accel_x;
        logic signed [CoordW-1:0] accel_y;
    } t_out_word;

    // Word moving down the square root chain.
    typedef struct packed {
        logic [SumW-1:0]   s;
        logic [SqRemW-1:0] rem;
        logic [RootW-1:0]  root;
        logic [ProdW-1:0]  nx;
        logic [ProdW-1:0]  ny;
        logic              negx;
        logic              negy;
    } t_sq_lane;

    // Word moving down the divider chain; x and y share the divisor.
    typedef struct packed {
        logic [RootW-1:0]   m;
        logic [DivRemW-1:0] remx;
        logic [DivRemW-1:0] remy;
        logic [QuotW-1:0]   nx;
        logic [QuotW-1:0]   ny;
        logic [QuotW-1:0]   qx;
        logic [QuotW-1:0]   qy;
        logic               negx;
        logic               negy;
        logic               zero;
    } t_div_lane;

endpackage

### rtl/sfs_sqrt_cell.sv
// One digit cell of the restoring square root chain.
module sfs_sqrt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  sfs_pkg::t_sq_lane i_lane,
    output logic              o_valid,
    output sfs_pkg::t_sq_lane o_lane
);

    logic                          r_valid;
    sfs_pkg::t_sq_lane             r_lane;
    sfs_pkg::t_sq_lane             n_lane;
    logic [sfs_pkg::SqRemW+1:0]    rem4;
    logic [sfs_pkg::SqRemW+1:0]    trial;

    always_comb begin
        rem4   = {i_lane.rem, i_lane.s[sfs_pkg::SumW-1 -: 2]};
        trial  = {2'b00, i_lane.root, 2'b01};
        n_lane = i_lane;
        n_lane.s = {i_lane.s[sfs_pkg::SumW-3:0], 2'b00};
        if (rem4 >= trial) begin
            n_lane.rem  = sfs_pkg::SqRemW'(rem4 - trial);
            n_lane.root = {i_lane.root[sfs_pkg::RootW-2:0], 1'b1};
        end else begin
            n_lane.rem  = sfs_pkg::SqRemW'(rem4);
            n_lane.root = {i_lane.root[sfs_pkg::RootW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

### rtl/sfs_div_cell.sv
// One quotient bit cell of the restoring divider chain, x and y side by side.
module sfs_div_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  sfs_pkg::t_div_lane i_lane,
    output logic               o_valid,
    output sfs_pkg::t_div_lane o_lane
);

    logic                        r_valid;
    sfs_pkg::t_div_lane          r_lane;
    sfs_pkg::t_div_lane          n_lane;
    logic [sfs_pkg::DivRemW:0]   rx2;
    logic [sfs_pkg::DivRemW:0]   ry2;
    logic [sfs_pkg::DivRemW:0]   mext;

    always_comb begin
        rx2    = {i_lane.remx, i_lane.nx[sfs_pkg::QuotW-1]};
        ry2    = {i_lane.remy, i_lane.ny[sfs_pkg::QuotW-1]};
        mext   = {1'b0, i_lane.m};
        n_lane = i_lane;
        n_lane.nx = {i_lane.nx[sfs_pkg::QuotW-2:0], 1'b0};
        n_lane.ny = {i_lane.ny[sfs_pkg::QuotW-2:0], 1'b0};
        if (rx2 >= mext) begin
            n_lane.remx = sfs_pkg::DivRemW'(rx2 - mext);
            n_lane.qx   = {i_lane.qx[sfs_pkg::QuotW-2:0], 1'b1};
        end else begin
            n_lane.remx = sfs_pkg::DivRemW'(rx2);
            n_lane.qx   = {i_lane.qx[sfs_pkg::QuotW-2:0], 1'b0};
        end
        if (ry2 >= mext) begin
            n_lane.remy = sfs_pkg::DivRemW'(ry2 - mext);
            n_lane.qy   = {i_lane.qy[sfs_pkg::QuotW-2:0], 1'b1};
        end else begin
            n_lane.remy = sfs_pkg::DivRemW'(ry2);
            n_lane.qy   = {i_lane.qy[sfs_pkg::QuotW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

### rtl/seek_flee_steering.sv
// Path from an accepted input word to its output word: 3 front stages,
// 33 square root cells, 31 divider cells, 1 output register.
// Throughput: one word per cycle while o_stall is low; the chains hold one word per cell.
// A one-word skid stage behind the chains lets one more word in while the output waits.
// Reset (synchronous, active low) empties all valid bits and sets max_accel to 1.0.
module seek_flee_steering #(
    parameter int unsigned FRAC_BITS = sfs_pkg::FracBitsDefault
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  sfs_pkg::t_in_word               i_in,
    output logic                            o_valid,
    input  logic                            i_stall,
    output sfs_pkg::t_out_word              o_out,
    input  logic                            i_cfg_we,
    input  logic [sfs_pkg::AccelW-1:0]      i_cfg_data
);

    localparam int unsigned SqCells  = sfs_pkg::RootW;
    localparam int unsigned DivCells = sfs_pkg::QuotW;

    logic [sfs_pkg::AccelW-1:0] r_max_accel;
    logic                       en;

    // Front stage 1: absolute differences and result signs.
    logic                       r_v1;
    logic [sfs_pkg::DiffW-1:0]  r_ax, r_ay;
    logic                       r_negx1, r_negy1;
    logic signed [sfs_pkg::DiffW-1:0] dx, dy;

    // Front stage 2: squares and numerators.
    logic                       r_v2;
    logic [sfs_pkg::SumW-1:0]   r_sx, r_sy;
    logic [sfs_pkg::ProdW-1:0]  r_nx2, r_ny2;
    logic                       r_negx2, r_negy2;

    // Front stage 3: sum of squares, start of the root chain.
    logic                       r_v3;
    sfs_pkg::t_sq_lane          r_sq0;

    logic                       sq_v [SqCells+1];
    sfs_pkg::t_sq_lane          sq_l [SqCells+1];
    logic                       dv_v [DivCells+1];
    sfs_pkg::t_div_lane         dv_l [DivCells+1];

    sfs_pkg::t_out_word         tail_word;
    logic                       r_ov;
    sfs_pkg::t_out_word         r_out;
    logic                       r_skv;
    sfs_pkg::t_out_word         r_skid;
    logic                       out_free;

    assign en      = !r_skv;
    assign o_stall = r_skv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_accel <= sfs_pkg::AccelW'(64'd1 << FRAC_BITS);
        end else if (i_cfg_we) begin
            r_max_accel <= i_cfg_data;
        end
    end

    always_comb begin
        dx = sfs_pkg::DiffW'(i_in.target_x) - sfs_pkg::DiffW'(i_in.pos_x);
        dy = sfs_pkg::DiffW'(i_in.target_y) - sfs_pkg::DiffW'(i_in.pos_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        if (en) begin
            r_ax    <= dx[sfs_pkg::DiffW-1] ? sfs_pkg::DiffW'(-dx) : sfs_pkg::DiffW'(dx);
            r_ay    <= dy[sfs_pkg::DiffW-1] ? sfs_pkg::DiffW'(-dy) : sfs_pkg::DiffW'(dy);
            r_negx1 <= dx[sfs_pkg::DiffW-1] ^ (i_in.cmd == sfs_pkg::CmdFlee);
            r_negy1 <= dy[sfs_pkg::DiffW-1] ^ (i_in.cmd == sfs_pkg::CmdFlee);

            r_sx    <= sfs_pkg::SumW'(r_ax * r_ax);
            r_sy    <= sfs_pkg::SumW'(r_ay * r_ay);
            r_nx2   <= sfs_pkg::ProdW'(r_ax * r_max_accel);
            r_ny2   <= sfs_pkg::ProdW'(r_ay * r_max_accel);
            r_negx2 <= r_negx1;
            r_negy2 <= r_negy1;

            r_sq0.s    <= r_sx + r_sy;
            r_sq0.rem  <= '0;
            r_sq0.root <= '0;
            r_sq0.nx   <= r_nx2;
            r_sq0.ny   <= r_ny2;
            r_sq0.negx <= r_negx2;
            r_sq0.negy <= r_negy2;
        end
    end

    assign sq_v[0] = r_v3;
    assign sq_l[0] = r_sq0;

    for (genvar k = 0; k < SqCells; k++) begin : g_sq
        sfs_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_v[k]),
            .i_lane  (sq_l[k]),
            .o_valid (sq_v[k+1]),
            .o_lane  (sq_l[k+1])
        );
    end

    // The quotient fits in the register width, so the top numerator bits start as remainder.
    always_comb begin
        dv_v[0]      = sq_v[SqCells];
        dv_l[0].m    = sq_l[SqCells].root;
        dv_l[0].remx = sq_l[SqCells].nx[sfs_pkg::ProdW-1:sfs_pkg::QuotW];
        dv_l[0].remy = sq_l[SqCells].ny[sfs_pkg::ProdW-1:sfs_pkg::QuotW];
        dv_l[0].nx   = sq_l[SqCells].nx[sfs_pkg::QuotW-1:0];
        dv_l[0].ny   = sq_l[SqCells].ny[sfs_pkg::QuotW-1:0];
        dv_l[0].qx   = '0;
        dv_l[0].qy   = '0;
        dv_l[0].negx = sq_l[SqCells].negx;
        dv_l[0].negy = sq_l[SqCells].negy;
        dv_l[0].zero = (sq_l[SqCells].root == '0);
    end

    for (genvar k = 0; k < DivCells; k++) begin : g_div
        sfs_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_v[k]),
            .i_lane  (dv_l[k]),
            .o_valid (dv_v[k+1]),
            .o_lane  (dv_l[k+1])
        );
    end

    always_comb begin
        logic [sfs_pkg::CoordW-1:0] qx, qy;
        qx = sfs_pkg::CoordW'(dv_l[DivCells].qx);
        qy = sfs_pkg::CoordW'(dv_l[DivCells].qy);
        if (dv_l[DivCells].zero) begin
            tail_word.accel_x = '0;
            tail_word.accel_y = '0;
        end else begin
            tail_word.accel_x = dv_l[DivCells].negx ? -qx : qx;
            tail_word.accel_y = dv_l[DivCells].negy ? -qy : qy;
        end
    end

    assign out_free = !r_ov || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_skv <= 1'b0;
        end else begin
            if (r_skv) begin
                if (out_free) begin
                    r_ov  <= 1'b1;
                    r_skv <= 1'b0;
                end
            end else if (out_free) begin
                r_ov <= dv_v[DivCells];
            end else if (dv_v[DivCells]) begin
                r_skv <= 1'b1;
            end
        end
        if (r_skv) begin
            if (out_free) begin
                r_out <= r_skid;
            end
        end else if (out_free) begin
            r_out <= tail_word;
        end else begin
            r_skid <= tail_word;
        end
    end

    assign o_valid = r_ov;
    assign o_out   = r_out;

endmodule

### rtl/sfs_checker.sv
// Port-level checks for the seek/flee steering block, bound to the top level.
module sfs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input sfs_pkg::t_out_word o_out
);

    // A held output word stays put until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out))
        else $error("output word changed while stalled");

    // The skid stage only fills when the output register is held.
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stall raised without a held output");

    // A full skid stage implies a full output register.
    a_skid_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("skid full with empty output");

    // Reset empties both sides.
    a_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid && !o_stall)
        else $error("valid or stall after reset");

endmodule

bind seek_flee_steering sfs_checker u_sfs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_out   (o_out)
);
